[rtl/zdle_escape_decoder_core_macros.svh]
// Assertion macros shared by the ZDLE decoder RTL.
`ifndef ZDLE_ESCAPE_DECODER_CORE_MACROS_SVH
`define ZDLE_ESCAPE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ZDLE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("zdle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ZDLE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("zdle check failed");

`endif

[rtl/zdle_pkg.sv]
// Types and byte codes for the ZDLE escape decoder.
package zdle_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_TERM = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  localparam logic [7:0] ESC_BYTE   = 8'h18;
  localparam logic [7:0] TERM_LO    = 8'h68;
  localparam logic [7:0] TERM_HI    = 8'h6B;
  localparam logic [7:0] RUB0_BYTE  = 8'h6C;
  localparam logic [7:0] RUB1_BYTE  = 8'h6D;
  localparam logic [7:0] RUB0_VALUE = 8'h7F;
  localparam logic [7:0] RUB1_VALUE = 8'hFF;
  localparam logic [7:0] CLASS_MASK = 8'h60;
  localparam logic [7:0] FLIP_BIT   = 8'h40;

  // One decoded word, or none, for the byte being consumed.
  typedef struct packed {
    logic       has_result;
    kind_t      kind;
    logic [7:0] value;
  } dec_res_t;

endpackage

[rtl/zdle_in_stage.sv]
// Input register for raw line bytes.
module zdle_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import zdle_pkg::*;

  logic       valid;
  logic [7:0] data;

  // Take a new word when empty or when the held one leaves this cycle.
  assign s_axis_tready = !valid || advance;
  assign byte_valid    = valid;
  assign byte_data     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data <= s_axis_tdata;
    end
  end

endmodule

[rtl/zdle_decode.sv]
// Escape state flag and decode of the held byte.
module zdle_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        byte_data,
  output logic              pending,
  output zdle_pkg::dec_res_t res
);
  import zdle_pkg::*;

  logic escape_pending;
  logic escape_pending_next;

  assign pending = escape_pending;

  always_comb begin
    res                 = '0;
    res.kind            = KIND_DATA;
    res.value           = byte_data;
    escape_pending_next = 1'b0;
    if (!escape_pending) begin
      if (byte_data == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        res.has_result = 1'b1;
      end
    end else begin
      res.has_result = 1'b1;
      priority if (byte_data >= TERM_LO && byte_data <= TERM_HI) begin
        res.kind = KIND_TERM;
      end else if (byte_data == RUB0_BYTE) begin
        res.value = RUB0_VALUE;
      end else if (byte_data == RUB1_BYTE) begin
        res.value = RUB1_VALUE;
      end else if ((byte_data & CLASS_MASK) == FLIP_BIT) begin
        res.value = byte_data ^ FLIP_BIT;
      end else begin
        res.kind = KIND_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

[rtl/zdle_out_stage.sv]
// Result register on the master side.
module zdle_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  zdle_pkg::dec_res_t res,
  output logic               can_take,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // value
  output logic [1:0]         m_axis_tuser   // kind
);
  import zdle_pkg::*;

  logic       valid;
  logic [7:0] value;
  kind_t      kind;

  assign can_take      = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = value;
  assign m_axis_tuser  = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance && res.has_result) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      value <= res.value;
      kind  <= res.kind;
    end
  end

endmodule

[rtl/zdle_escape_decoder_core.sv]
// ZDLE escape decoder top level.
// Takes one raw line byte per word and removes ZDLE escaping: plain bytes come out as data,
// an escape byte 0x18 gives no word but arms the decoder, and the byte after it comes out as
// a restored data byte, a subpacket terminator or a bad-escape error (tuser 0/1/2). The
// block takes a byte every cycle while the master side keeps up. A byte is held in the input
// register and decoded from there, and its result is registered in the result register that
// drives the master side. The only loop is the one-bit escape flag, updated in the same
// cycle the byte is decoded. A stalled master side holds the result register and then the
// input register, and the slave side stops taking bytes.
module zdle_escape_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] value
  output logic [1:0] m_axis_tuser    // [1:0] kind
);
  import zdle_pkg::*;

  `include "zdle_escape_decoder_core_macros.svh"

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       can_take;
  logic       advance;
  logic       pending;
  dec_res_t   res;

  assign advance = byte_valid && can_take;

  zdle_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .advance      (advance),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  zdle_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .byte_data(byte_data),
    .pending  (pending),
    .res      (res)
  );

  zdle_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .res          (res),
    .can_take     (can_take),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  `ZDLE_ASSERT_NEXT(a_esc_arms, advance && !pending && byte_data == ESC_BYTE, pending)
  `ZDLE_ASSERT_NEXT(a_partner_clears, advance && pending, !pending)
  `ZDLE_ASSERT_NOW(a_term_range, m_axis_tvalid && m_axis_tuser == KIND_TERM,
    m_axis_tdata >= TERM_LO && m_axis_tdata <= TERM_HI)
  `ZDLE_ASSERT_NOW(a_bare_esc_silent, advance && !pending && byte_data == ESC_BYTE,
    !res.has_result)

endmodule

[bench/tb_zdle_escape_decoder_core.sv]
// Self-checking testbench for the ZDLE escape decoder core.
`timescale 1ns / 100ps

module tb_zdle_escape_decoder_core;
  import zdle_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } dec_word_t;

  // Predicts decoded words from accepted line bytes and checks them in order.
  class zdle_scoreboard;
    bit          esc_armed;
    dec_word_t   expected_words[$];
    int unsigned mismatches;

    function new();
      esc_armed   = 1'b0;
      mismatches  = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      dec_word_t w;
      if (!esc_armed) begin
        if (b == ESC_BYTE) begin
          esc_armed = 1'b1;
          return;
        end
        w.kind  = KIND_DATA;
        w.value = b;
      end else begin
        // any byte after an escape disarms, including a second escape
        esc_armed = 1'b0;
        if (b >= TERM_LO && b <= TERM_HI) begin
          w.kind  = KIND_TERM;
          w.value = b;
        end else if (b == RUB0_BYTE) begin
          w.kind  = KIND_DATA;
          w.value = RUB0_VALUE;
        end else if (b == RUB1_BYTE) begin
          w.kind  = KIND_DATA;
          w.value = RUB1_VALUE;
        end else if ((b & CLASS_MASK) == FLIP_BIT) begin
          w.kind  = KIND_DATA;
          w.value = b ^ FLIP_BIT;
        end else begin
          w.kind  = KIND_BAD;
          w.value = b;
        end
      end
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [1:0] kind, logic [7:0] value);
      dec_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d value 0x%02h", $time, kind, value);
        mismatches++;
        return;
      end
      w = expected_words.pop_front();
      if (kind !== w.kind) begin
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, w.kind, kind);
        mismatches++;
      end
      if (value !== w.value) begin
        $display("%0t: value mismatch, expected 0x%02h actual 0x%02h", $time, w.value, value);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;   // [7:0] value
  logic [1:0] m_axis_tuser;   // [1:0] kind

  zdle_scoreboard words_sb = new();
  int unsigned    items_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    cycle_count = 0;
  logic [15:0]    ready_pat = '1;
  int unsigned    ready_pos = 0;

  zdle_escape_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: a 16-bit pattern reloaded each time it is played out, from no stall to heavy stall.
  always @(posedge clk) begin
    if (ready_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = '1;
        1:       ready_pat = 16'($urandom);
        2:       ready_pat = 16'($urandom & $urandom & $urandom);
        default: ready_pat = 16'($urandom | $urandom);
      endcase
    end
    m_axis_tready <= ready_pat[ready_pos];
    ready_pos = (ready_pos + 1) % 16;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) words_sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) words_sb.check_word(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("zdle_escape_decoder_core verification failed");
      $finish;
    end
  end

  // Sends one word; bursts of random length separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Partner byte for an escape, biased toward the decoded classes.
  function automatic logic [7:0] escape_partner();
    logic [7:0] r;
    r = 8'($urandom);
    case ($urandom_range(0, 5))
      0: r = TERM_LO + 8'($urandom_range(0, 3));
      1: r = RUB0_BYTE;
      2: r = RUB1_BYTE;
      3: r[6:5] = 2'b10;
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    logic [7:0]  directed_seq[$];
    int unsigned start_count;
    directed_seq = '{8'h00, 8'hFF,
                     ESC_BYTE, TERM_LO, ESC_BYTE, TERM_LO + 8'd1,
                     ESC_BYTE, TERM_LO + 8'd2, ESC_BYTE, TERM_HI,
                     ESC_BYTE, RUB0_BYTE, ESC_BYTE, RUB1_BYTE,
                     ESC_BYTE, 8'hC0, ESC_BYTE, 8'h5F,
                     ESC_BYTE, ESC_BYTE, 8'h41,
                     ESC_BYTE, 8'hFF, ESC_BYTE, 8'h00};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    // mostly plain bytes and escape pairs; the rest is raw noise incl. stray escapes
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_byte(8'($urandom));
        6, 7, 8: begin
          send_byte(ESC_BYTE);
          send_byte(escape_partner());
        end
        default: begin
          send_byte(ESC_BYTE);
          send_byte($urandom_range(0, 1) ? ESC_BYTE : 8'($urandom));
        end
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (words_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (words_sb.mismatches == 0 && words_sb.outstanding() == 0) begin
      $display("zdle_escape_decoder_core verification clean");
    end else begin
      $display("zdle_escape_decoder_core verification failed");
    end
    $finish;
  end

endmodule
